### design/ppdn_pkg.sv
// ----------------------------------------------------------------------------
// ppdn_pkg
// Shared widths for the point pair direction normalizer.
// ----------------------------------------------------------------------------
package ppdn_pkg;

    localparam int COORD_WIDTH   = 32;
    localparam int OUT_FRAC_BITS = 30;

    localparam int DIFF_W = COORD_WIDTH + 1;
    localparam int MAG_W  = COORD_WIDTH + 1;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int SUM_W  = SQ_W + 2;
    localparam int OUT_W  = OUT_FRAC_BITS + 2;
    localparam int STEPS  = OUT_FRAC_BITS + 1;
    // holds d^2 << 2F plus headroom for the trial increment
    localparam int WIDE_W = SQ_W + 2 * OUT_FRAC_BITS + 3;

    localparam int IN_TDATA_W  = ((6 * COORD_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((3 * OUT_W + 7) / 8) * 8;

    localparam int DIV_LAT = STEPS + 2;
    localparam int LAT     = 3 + DIV_LAT;

endpackage

### design/ppdn_div.sv
// ----------------------------------------------------------------------------
// ppdn_div
// Pipelined bit-per-stage search of floor(|d| * 2^F / sqrt(S)).
// ----------------------------------------------------------------------------
module ppdn_div
    import ppdn_pkg::*;
(
    input  logic                clk,
    input  logic                en,
    input  logic [SQ_W-1:0]     sq,
    input  logic [SUM_W-1:0]    sum,
    input  logic                neg,
    input  logic                zero,
    output logic [OUT_W-1:0]    unit,
    output logic                zero_out
);

    // r: remaining d^2*2^2F - q^2*S, p: q*S
    logic [WIDE_W-1:0] r_reg    [STEPS+1];
    logic [WIDE_W-1:0] p_reg    [STEPS+1];
    logic [WIDE_W-1:0] s_reg    [STEPS+1];
    logic [STEPS-1:0]  q_reg    [STEPS+1];
    logic              neg_reg  [STEPS+1];
    logic              zero_reg [STEPS+1];
    logic [OUT_W-1:0]  unit_reg;
    logic              zero_out_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0]    <= WIDE_W'(sq) << (2 * OUT_FRAC_BITS);
            p_reg[0]    <= '0;
            s_reg[0]    <= WIDE_W'(sum);
            q_reg[0]    <= '0;
            neg_reg[0]  <= neg;
            zero_reg[0] <= zero;
        end
    end

    genvar k;
    generate
        for (k = 0; k < STEPS; k++)
        begin : g_step
            localparam int B = OUT_FRAC_BITS - k;
            logic [WIDE_W-1:0] inc;
            logic              take;

            // (q + 2^B)^2 S - q^2 S = q*S*2^(B+1) + S*2^(2B)
            assign inc  = (p_reg[k] << (B + 1)) + (s_reg[k] << (2 * B));
            assign take = (inc <= r_reg[k]);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r_reg[k+1]    <= take ? r_reg[k] - inc : r_reg[k];
                    p_reg[k+1]    <= take ? p_reg[k] + (s_reg[k] << B) : p_reg[k];
                    q_reg[k+1]    <= take ? (q_reg[k] | (STEPS'(1) << B)) : q_reg[k];
                    s_reg[k+1]    <= s_reg[k];
                    neg_reg[k+1]  <= neg_reg[k];
                    zero_reg[k+1] <= zero_reg[k];
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (zero_reg[STEPS])
                unit_reg <= '0;
            else if (neg_reg[STEPS])
                unit_reg <= OUT_W'(0) - OUT_W'(q_reg[STEPS]);
            else
                unit_reg <= OUT_W'(q_reg[STEPS]);
            zero_out_reg <= zero_reg[STEPS];
        end
    end

    assign unit     = unit_reg;
    assign zero_out = zero_out_reg;

endmodule

### design/point_pair_direction_normalize_core.sv
// ----------------------------------------------------------------------------
// point_pair_direction_normalize_core
// Unit direction from two Q16.16 points, result in signed Q2.30.
// ----------------------------------------------------------------------------
// channel  | dir | signals                     | contents
// s_axis   | in  | s_tvalid s_tready s_tdata   | start xyz, end xyz
// m_axis   | out | m_tvalid m_tready m_tdata   | unit xyz, tuser zero_length
//
// one beat in per cycle while the output is not stalled; stages: 3 front stages,
// one search load stage, STEPS search stages set by OUT_FRAC_BITS, one output register
// the whole pipeline advances together when the output is free or taken
// a stalled output freezes every stage, nothing is dropped or repeated
// reset clears only the valid bits
// ----------------------------------------------------------------------------
module point_pair_direction_normalize_core
    import ppdn_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // start_x, start_y, start_z, end_x, end_y, end_z
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // unit_x, unit_y, unit_z
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // zero_length
    output logic                   m_tuser
);

    logic            en;
    logic [LAT-1:0]  vld_reg;

    logic signed [DIFF_W-1:0] d_reg   [3];
    logic [SQ_W-1:0]          sq_reg  [3];
    logic                     neg_reg [3];
    logic                     nz_reg  [3];
    logic [SQ_W-1:0]          sq3_reg [3];
    logic                     neg3_reg[3];
    logic [SUM_W-1:0]         sum_reg;
    logic                     zero_reg;
    logic [OUT_W-1:0]         unit    [3];
    logic                     zflag   [3];

    assign en       = !vld_reg[LAT-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
    end

    genvar i;
    generate
        for (i = 0; i < 3; i++)
        begin : g_axis
            logic signed [COORD_WIDTH-1:0] a;
            logic signed [COORD_WIDTH-1:0] b;
            logic [MAG_W-1:0]              mag;

            assign a   = s_tdata[i*COORD_WIDTH +: COORD_WIDTH];
            assign b   = s_tdata[(i+3)*COORD_WIDTH +: COORD_WIDTH];
            assign mag = d_reg[i][DIFF_W-1] ? MAG_W'(-d_reg[i]) : MAG_W'(d_reg[i]);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    d_reg[i]    <= DIFF_W'(b) - DIFF_W'(a);
                    sq_reg[i]   <= SQ_W'(mag) * SQ_W'(mag);
                    neg_reg[i]  <= d_reg[i][DIFF_W-1];
                    nz_reg[i]   <= (d_reg[i] != '0);
                    sq3_reg[i]  <= sq_reg[i];
                    neg3_reg[i] <= neg_reg[i];
                end
            end

            ppdn_div u_div
            (
                .clk      (clk),
                .en       (en),
                .sq       (sq3_reg[i]),
                .sum      (sum_reg),
                .neg      (neg3_reg[i]),
                .zero     (zero_reg),
                .unit     (unit[i]),
                .zero_out (zflag[i])
            );
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg  <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
            zero_reg <= !(nz_reg[0] || nz_reg[1] || nz_reg[2]);
        end
    end

    assign m_tdata = OUT_TDATA_W'({unit[2], unit[1], unit[0]});
    assign m_tuser = zflag[0];

    localparam logic signed [OUT_W-1:0] ONE = OUT_W'(1) << OUT_FRAC_BITS;

    // zero length gives all-zero components
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> unit[0] == '0 && unit[1] == '0 && unit[2] == '0)
        else $error("zero length with nonzero component");

    // components stay within [-1, +1]
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $signed(unit[0]) <= ONE && $signed(unit[0]) >= -ONE
                  && $signed(unit[1]) <= ONE && $signed(unit[1]) >= -ONE
                  && $signed(unit[2]) <= ONE && $signed(unit[2]) >= -ONE)
        else $error("unit component out of range");

    // a blocked output holds the input side
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while output stalled");

    // the three lanes agree on the zero flag
    a_zflag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> zflag[1] == zflag[0] && zflag[2] == zflag[0])
        else $error("zero flag differs between lanes");

endmodule
